// File: src/seek_arrive_steering_defines.svh
// ----------------------------------------------------------------------------
// seek_arrive_steering_defines.svh
// Assertion macros used by the steering pipeline top module.
// ----------------------------------------------------------------------------
`ifndef SEEK_ARRIVE_STEERING_DEFINES_SVH
`define SEEK_ARRIVE_STEERING_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define SAS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define SAS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SAS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Types, widths and stage positions of the seek/arrive steering pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

    localparam int DIST_W   = 32;   // floor(sqrt) of a 64-bit sum
    localparam int QUO_W    = 31;   // quotient bits of both divisions
    localparam int SPD_W    = 31;
    localparam int NUM_W    = 52;   // dist * 655360
    localparam int DEN_W    = 33;   // decel_factor * 3
    localparam int PROD_W   = 62;   // mag * speed
    localparam int ROOT_REM_W = 34;

    // stage positions along the chain
    localparam int ST_SQR   = 0;
    localparam int ST_SUM   = 1;
    localparam int ST_ROOT0 = 2;
    localparam int ST_RAT   = ST_ROOT0 + DIST_W;
    localparam int ST_QDIV0 = ST_RAT + 1;
    localparam int ST_SPD   = ST_QDIV0 + QUO_W;
    localparam int ST_PROD  = ST_SPD + 1;
    localparam int ST_CDIV0 = ST_PROD + 1;
    localparam int ST_OUT   = ST_CDIV0 + QUO_W;
    localparam int N_ST     = ST_OUT + 1;

    typedef enum logic [1:0] {
        REG_MAX_SPEED  = 2'd0,
        REG_NEAR_RANGE = 2'd1,
        REG_DECEL      = 2'd2,
        REG_NONE       = 2'd3
    } reg_idx_t;

    // per-item data that rides along beside the arithmetic cells
    typedef struct packed {
        logic signed [2:0][31:0] vel;
        logic signed [2:0][31:0] tov;
        logic        [2:0][31:0] mag;
        logic [DIST_W-1:0]       dist_val;
        logic                    arrive;
        logic                    ovf;
        logic [SPD_W-1:0]        speed;
    } side_t;

endpackage

`default_nettype wire

// File: src/seek_arrive_steering.sv
// Throughput: one item per cycle while the result beat is not stalled; the
// chain of root and divider cells settles one bit per cell, 32 root cells, 31
// speed-divider cells, 31 component cells in each of three lanes.
// A stalled result beat holds the whole chain until it is taken.
// Reset (aresetn low, synchronous) empties the chain and restores max_speed,
// near_range and decel_factor to their reset values.
// ----------------------------------------------------------------------------
// seek_arrive_steering
// Seek/arrive steering vector from velocity and vector to target, Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none
`include "seek_arrive_steering_defines.svh"

module seek_arrive_steering
    import sas_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // input beats
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_vel_x,
    input  wire logic signed [31:0] s_vel_y,
    input  wire logic signed [31:0] s_vel_z,
    input  wire logic signed [31:0] s_to_x,
    input  wire logic signed [31:0] s_to_y,
    input  wire logic signed [31:0] s_to_z,
    // result beats
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_steer_x,
    output logic signed [31:0]      m_steer_y,
    output logic signed [31:0]      m_steer_z,
    output logic                    m_arrive_mode
);

    logic [30:0] max_speed_reg;
    logic [30:0] near_range_reg;
    logic [30:0] decel_reg;
    reg_idx_t    cfg_idx;

    logic        adv;
    logic        vld_reg [N_ST];
    side_t       sb_reg  [N_ST];
    side_t       sb_next [N_ST];

    logic [2:0][63:0] sqr_reg;
    logic [63:0]      sum_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [2:0][PROD_W-1:0] prod_reg;
    logic signed [2:0][31:0] steer_reg;
    logic        arrive_out_reg;

    logic [63:0]           rt_n [DIST_W+1];
    logic [ROOT_REM_W-1:0] rt_r [DIST_W+1];
    logic [DIST_W-1:0]     rt_q [DIST_W+1];

    logic [DEN_W-1:0] qd_d  [QUO_W+1];
    logic [DEN_W-1:0] qd_r  [QUO_W+1];
    logic [QUO_W-1:0] qd_lo [QUO_W+1];
    logic [QUO_W-1:0] qd_q  [QUO_W+1];

    logic [DIST_W-1:0] cd_d  [3][QUO_W+1];
    logic [DIST_W-1:0] cd_r  [3][QUO_W+1];
    logic [QUO_W-1:0]  cd_lo [3][QUO_W+1];
    logic [QUO_W-1:0]  cd_q  [3][QUO_W+1];

    logic [DIST_W-1:0] dist_c;
    logic [QUO_W-1:0]  quo_c;
    logic [SPD_W-1:0]  speed_c;
    logic signed [2:0][31:0] to_in;
    logic signed [2:0][31:0] vel_in;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg  <= 31'd327680;
            near_range_reg <= 31'd655360;
            decel_reg      <= 31'd65536;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                REG_MAX_SPEED:  max_speed_reg  <= pwdata[30:0];
                REG_NEAR_RANGE: near_range_reg <= pwdata[30:0];
                REG_DECEL:      decel_reg      <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MAX_SPEED:  prdata = {1'b0, max_speed_reg};
            REG_NEAR_RANGE: prdata = {1'b0, near_range_reg};
            REG_DECEL:      prdata = {1'b0, decel_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // advance the whole chain unless the result beat is stalled
    assign adv     = !vld_reg[ST_OUT] || m_ready;
    assign s_ready = adv;

    assign to_in  = {s_to_z, s_to_y, s_to_x};
    assign vel_in = {s_vel_z, s_vel_y, s_vel_x};

    assign dist_c = rt_q[DIST_W];
    assign quo_c  = qd_q[QUO_W];

    // side data: pass along, fill fields at the stage that knows them
    always_comb begin
        sb_next[0]        = '0;
        sb_next[0].vel    = vel_in;
        sb_next[0].tov    = to_in;
        for (int i = 1; i < N_ST; i++) begin
            sb_next[i] = sb_reg[i-1];
        end
        for (int c = 0; c < 3; c++) begin
            sb_next[ST_SUM].mag[c] = sb_reg[ST_SQR].tov[c][31]
                ? (~sb_reg[ST_SQR].tov[c] + 32'd1) : sb_reg[ST_SQR].tov[c];
        end
        sb_next[ST_RAT].dist_val = dist_c;
        sb_next[ST_RAT].arrive   = ({1'b0, dist_c} <= {2'b0, near_range_reg});
        sb_next[ST_QDIV0].ovf  = ({{(DEN_W - NUM_W + QUO_W){1'b0}},
                                   num_reg[NUM_W-1:QUO_W]} >= den_reg);
        if (quo_c < max_speed_reg) begin
            speed_c = quo_c;
        end else begin
            speed_c = max_speed_reg;
        end
        if (!sb_reg[ST_SPD-1].arrive || sb_reg[ST_SPD-1].ovf) begin
            speed_c = max_speed_reg;
        end
        sb_next[ST_SPD].speed = speed_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_ST; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < N_ST; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N_ST; i++) begin
                sb_reg[i] <= sb_next[i];
            end
        end
    end

    // square, sum, ratio operands, products
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                sqr_reg[c]  <= 64'($signed(to_in[c]) * $signed(to_in[c]));
                prod_reg[c] <= PROD_W'(sb_reg[ST_SPD].mag[c] * sb_reg[ST_SPD].speed);
            end
            sum_reg <= sqr_reg[0] + sqr_reg[1] + sqr_reg[2];
            num_reg <= ({20'd0, dist_c} << 19) + ({20'd0, dist_c} << 17);
            den_reg <= ({2'b0, decel_reg} << 1) + {2'b0, decel_reg};
        end
    end

    // root cells
    assign rt_n[0] = sum_reg;
    assign rt_r[0] = '0;
    assign rt_q[0] = '0;

    for (genvar k = 0; k < DIST_W; k++) begin : g_root
        sas_root_cell u_cell (
            .aclk  (aclk),
            .en    (adv),
            .n_in  (rt_n[k]),
            .r_in  (rt_r[k]),
            .q_in  (rt_q[k]),
            .n_out (rt_n[k+1]),
            .r_out (rt_r[k+1]),
            .q_out (rt_q[k+1])
        );
    end

    // speed divider cells
    assign qd_d[0]  = den_reg;
    assign qd_r[0]  = {{(DEN_W - NUM_W + QUO_W){1'b0}}, num_reg[NUM_W-1:QUO_W]};
    assign qd_lo[0] = num_reg[QUO_W-1:0];
    assign qd_q[0]  = '0;

    for (genvar j = 0; j < QUO_W; j++) begin : g_qdiv
        sas_div_cell #(.DW(DEN_W)) u_cell (
            .aclk   (aclk),
            .en     (adv),
            .d_in   (qd_d[j]),
            .r_in   (qd_r[j]),
            .lo_in  (qd_lo[j]),
            .q_in   (qd_q[j]),
            .d_out  (qd_d[j+1]),
            .r_out  (qd_r[j+1]),
            .lo_out (qd_lo[j+1]),
            .q_out  (qd_q[j+1])
        );
    end

    // component divider lanes
    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign cd_d[l][0]  = sb_reg[ST_PROD].dist_val;
        assign cd_r[l][0]  = {1'b0, prod_reg[l][PROD_W-1:QUO_W]};
        assign cd_lo[l][0] = prod_reg[l][QUO_W-1:0];
        assign cd_q[l][0]  = '0;
        for (genvar j = 0; j < QUO_W; j++) begin : g_cdiv
            sas_div_cell #(.DW(DIST_W)) u_cell (
                .aclk   (aclk),
                .en     (adv),
                .d_in   (cd_d[l][j]),
                .r_in   (cd_r[l][j]),
                .lo_in  (cd_lo[l][j]),
                .q_in   (cd_q[l][j]),
                .d_out  (cd_d[l][j+1]),
                .r_out  (cd_r[l][j+1]),
                .lo_out (cd_lo[l][j+1]),
                .q_out  (cd_q[l][j+1])
            );
        end
    end

    // sign, subtract velocity, saturate; zero vector for a zero distance
    always_ff @(posedge aclk) begin
        logic signed [33:0] want;
        logic signed [33:0] diff;
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                want = {3'b000, cd_q[c][QUO_W]};
                if (sb_reg[ST_OUT-1].tov[c][31]) begin
                    want = -want;
                end
                diff = want - {{2{sb_reg[ST_OUT-1].vel[c][31]}}, sb_reg[ST_OUT-1].vel[c]};
                if (sb_reg[ST_OUT-1].dist_val == '0) begin
                    steer_reg[c] <= '0;
                end else if (diff > 34'sh0_7FFF_FFFF) begin
                    steer_reg[c] <= 32'sh7FFF_FFFF;
                end else if (diff < -34'sh0_8000_0000) begin
                    steer_reg[c] <= 32'sh8000_0000;
                end else begin
                    steer_reg[c] <= diff[31:0];
                end
            end
            arrive_out_reg <= sb_reg[ST_OUT-1].arrive;
        end
    end

    assign m_valid       = vld_reg[ST_OUT];
    assign m_steer_x     = steer_reg[0];
    assign m_steer_y     = steer_reg[1];
    assign m_steer_z     = steer_reg[2];
    assign m_arrive_mode = arrive_out_reg;

    // a zero distance always lands in the arrive branch with a zero vector
    `SAS_ASSERT_IMP(a_zero_arrive, aclk, aresetn,
        vld_reg[ST_OUT] && sb_reg[ST_OUT].dist_val == '0, m_arrive_mode)
    `SAS_ASSERT_IMP(a_zero_steer, aclk, aresetn,
        vld_reg[ST_OUT] && sb_reg[ST_OUT].dist_val == '0,
        m_steer_x == '0 && m_steer_y == '0 && m_steer_z == '0)
    // a stall leaves the result beat in place
    `SAS_ASSERT_NXT(a_stall_holds, aclk, aresetn, !s_ready, m_valid)
    // the chosen speed never exceeds the limit
    `SAS_ASSERT_IMP(a_speed_cap, aclk, aresetn,
        vld_reg[ST_SPD], sb_reg[ST_SPD].speed <= max_speed_reg)
    // seek is only taken beyond the near range
    `SAS_ASSERT_IMP(a_seek_far, aclk, aresetn,
        vld_reg[ST_RAT] && !sb_reg[ST_RAT].arrive,
        sb_reg[ST_RAT].dist_val > {1'b0, near_range_reg})

endmodule

`default_nettype wire

// File: src/sas_root_cell.sv
// ----------------------------------------------------------------------------
// sas_root_cell
// One digit step of a restoring square root: settles one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_root_cell
    import sas_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [63:0]           n_in,
    input  wire logic [ROOT_REM_W-1:0] r_in,
    input  wire logic [DIST_W-1:0]     q_in,
    output logic      [63:0]           n_out,
    output logic      [ROOT_REM_W-1:0] r_out,
    output logic      [DIST_W-1:0]     q_out
);

    logic [63:0]           n_reg;
    logic [ROOT_REM_W-1:0] r_reg;
    logic [DIST_W-1:0]     q_reg;
    logic [ROOT_REM_W+1:0] pull;
    logic [ROOT_REM_W+1:0] trial;
    logic                  fits;
    logic [ROOT_REM_W+1:0] diff;

    // bring down two bits and try root*4+1
    always_comb begin
        pull  = {r_in, n_in[63:62]};
        trial = {{(ROOT_REM_W - DIST_W){1'b0}}, q_in, 2'b01};
        fits  = (pull >= trial);
        diff  = fits ? (pull - trial) : pull;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= {n_in[61:0], 2'b00};
            r_reg <= diff[ROOT_REM_W-1:0];
            q_reg <= {q_in[DIST_W-2:0], fits};
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;
    assign q_out = q_reg;

endmodule

`default_nettype wire

// File: src/sas_div_cell.sv
// ----------------------------------------------------------------------------
// sas_div_cell
// One step of a restoring divider: settles one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_div_cell
    import sas_pkg::*;
#(
    parameter int DW = 32
)
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [DW-1:0]    d_in,
    input  wire logic [DW-1:0]    r_in,
    input  wire logic [QUO_W-1:0] lo_in,
    input  wire logic [QUO_W-1:0] q_in,
    output logic      [DW-1:0]    d_out,
    output logic      [DW-1:0]    r_out,
    output logic      [QUO_W-1:0] lo_out,
    output logic      [QUO_W-1:0] q_out
);

    logic [DW-1:0]    d_reg;
    logic [DW-1:0]    r_reg;
    logic [QUO_W-1:0] lo_reg;
    logic [QUO_W-1:0] q_reg;
    logic [DW:0]      pull;
    logic             fits;
    logic [DW:0]      diff;

    // bring down one numerator bit, subtract the divisor where it fits
    always_comb begin
        pull = {r_in, lo_in[QUO_W-1]};
        fits = (pull >= {1'b0, d_in});
        diff = fits ? (pull - {1'b0, d_in}) : pull;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg  <= d_in;
            r_reg  <= diff[DW-1:0];
            lo_reg <= {lo_in[QUO_W-2:0], 1'b0};
            q_reg  <= {q_in[QUO_W-2:0], fits};
        end
    end

    assign d_out  = d_reg;
    assign r_out  = r_reg;
    assign lo_out = lo_reg;
    assign q_out  = q_reg;

endmodule

`default_nettype wire
